>>> src/vts_pkg.sv
// Package for the vertex to screen transform: shared widths, reset values,
// register and mode codes, and the sequencer state type.
// No dependencies; every other file in src imports it.
`default_nettype none

package vts_pkg;

   localparam int DATA_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int SCREEN_W          = 13;
   localparam int OUT_W             = 16;
   localparam int ENTRY_IDX_W       = 5;
   localparam int CSR_ADDR_W        = 3;
   localparam int ROW_RES_N         = 8;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

   // Request modes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   // Register index as seen on address bit 2.
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DIV_X,
      ST_DIV_Y,
      ST_VPORT_X,
      ST_VPORT_Y,
      ST_FINISH,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

>>> src/vertex_to_screen_transform.sv
// Top level of the vertex to screen transform: matrix store, shared multiplier
// with its accumulate pipeline, sequencer, viewport mapping and APB registers.
// Depends on vts_pkg and vts_divider.
`default_nettype none

// A request with mode 0 writes one matrix entry in the cycle it is accepted
// and leaves busy low, so loads can be issued back to back. A request with
// mode 1 transforms a point and raises busy until its single result has been
// strobed on rsp_valid for one cycle; the receiver cannot stall and must take
// the result in that cycle. A point runs its multiplies on the single shared
// 33x32 multiplier (one matrix entry read per cycle from the 32-entry store),
// drains the multiply pipeline, runs two serial divides in the divider, and
// ends with the viewport mapping and the result; the divides are skipped
// when clip w comes out zero. The matrix store has no reset: every entry
// must be loaded before a point is sent. The user must write screen width
// and height through the APB port only while the block is idle; the block
// itself does not enforce this.
module vertex_to_screen_transform
   import vts_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          start,
   output logic                         busy,
   input  wire                          req_mode,
   input  wire  [ENTRY_IDX_W-1:0]       req_entry_index,
   input  wire  signed [DATA_W-1:0]     req_entry_value,
   input  wire  signed [DATA_W-1:0]     req_point_x,
   input  wire  signed [DATA_W-1:0]     req_point_y,
   input  wire  signed [DATA_W-1:0]     req_point_z,

   output logic                         rsp_valid,
   output logic signed [OUT_W-1:0]      rsp_screen_x,
   output logic signed [OUT_W-1:0]      rsp_screen_y,
   output logic                         rsp_w_was_zero,

   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]        csr_paddr,
   input  wire  [DATA_W-1:0]            csr_pwdata,
   output logic [DATA_W-1:0]            csr_prdata,
   output logic                         csr_pready
);

   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int MUL_A_W   = DATA_W + 1;
   localparam int PROD_W    = MUL_A_W + DATA_W;
   localparam int ACC_W     = 2 * DATA_W;
   localparam int MEM_DEPTH = 2 ** ENTRY_IDX_W;
   localparam int TAG_W     = ENTRY_IDX_W;
   localparam int ROW_W     = $clog2(ROW_RES_N);
   // Clip-space rows sit in the upper half of the row results.
   localparam int CLIP_X_IDX = ROW_RES_N / 2;
   localparam int CLIP_Y_IDX = CLIP_X_IDX + 1;

   localparam logic signed [DATA_W-1:0]  ONE_32 = DATA_W'(1) <<< FRAC_BITS;
   localparam logic signed [MUL_A_W-1:0] ONE_33 = MUL_A_W'(1) <<< FRAC_BITS;
   localparam logic signed [PROD_W-1:0]  VP_RND =
      (PROD_W'(1) <<< (FRAC_BITS + 1)) - PROD_W'(1);
   localparam logic [TAG_W-1:0] TAG_LAST = '1;

   // Saturate a 64-bit sum to 32 bits signed.
   function automatic logic signed [DATA_W-1:0] sat_w32(input logic signed [ACC_W-1:0] x);
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (x < 64'shFFFF_FFFF_8000_0000) begin
         return 32'sh8000_0000;
      end
      return x[DATA_W-1:0];
   endfunction

   // Divide a viewport product by 2*ONE toward zero and saturate to 16 bits.
   function automatic logic signed [OUT_W-1:0] vport_map(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] adj;
      logic signed [PROD_W-1:0] q;
      adj = p + ((p < 0) ? VP_RND : PROD_W'(0));
      q   = adj >>> (FRAC_BITS + 1);
      if (q > 65'sh0_0000_0000_0000_7FFF) begin
         return 16'sh7FFF;
      end else if (q < 65'sh1_FFFF_FFFF_FFFF_8000) begin
         return 16'sh8000;
      end
      return q[OUT_W-1:0];
   endfunction

   // Sequencer.
   state_type state_ff, state_in;

   // Controls decoded from the state, the pipeline and the APB port.
   logic load_we;
   logic accept_point;
   logic issue;
   logic drained;
   logic div_start;
   logic cfg_we;

   // Configuration registers.
   logic [SCREEN_W-1:0] width_ff, width_in;
   logic [SCREEN_W-1:0] height_ff, height_in;

   // Matrix store and its registered read port.
   logic [DATA_W-1:0] matrix_store_ff [MEM_DEPTH];
   logic [DATA_W-1:0] mem_rdata_ff;
   logic [ENTRY_IDX_W-1:0] mem_addr;

   // Captured point.
   logic signed [DATA_W-1:0] point_ff [3];
   logic signed [DATA_W-1:0] point_in [3];

   // Multiply-accumulate pipeline.
   logic [TAG_W-1:0]         cnt_ff, cnt_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [TAG_W-1:0]         s1_tag_ff, s1_tag_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic [TAG_W-1:0]         s2_tag_ff, s2_tag_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [DATA_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  product_ff, product_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0]   sum;
   logic                      res_we;
   logic [ROW_W-1:0]          res_idx;
   logic signed [DATA_W-1:0]  res_in;
   logic signed [DATA_W-1:0]  res_ff [ROW_RES_N];

   // Divide and viewport stage.
   logic signed [NUM_W-1:0]  div_num;
   logic                     div_done;
   logic signed [NUM_W:0]    div_quotient;
   logic signed [ACC_W-1:0]  div_q_ext;
   logic signed [DATA_W-1:0] div_q_sat;
   logic                     w_zero;
   logic signed [DATA_W-1:0] nx_ff, nx_in;
   logic signed [DATA_W-1:0] ny_ff, ny_in;
   logic                     wz_ff, wz_in;
   logic signed [OUT_W-1:0]  sx_ff, sx_in;
   logic signed [OUT_W-1:0]  sy_ff, sy_in;

   //--------------------------------------------------------------------------
   // Next-state logic. A point runs the 32 multiply-accumulate steps, waits
   // for the pipeline to empty, divides x and y by w unless w is zero, and
   // then maps both coordinates onto the viewport.
   //--------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_mode == MODE_POINT) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (cnt_ff == TAG_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drained) state_in = w_zero ? ST_VPORT_X : ST_DIV_X;
         end
         ST_DIV_X: begin
            if (div_done) state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            if (div_done) state_in = ST_VPORT_X;
         end
         ST_VPORT_X: state_in = ST_VPORT_Y;
         ST_VPORT_Y: state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_RESULT;
         ST_RESULT:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   //--------------------------------------------------------------------------
   // Outputs of the sequencer.
   //--------------------------------------------------------------------------
   always_comb begin
      busy         = 1'b1;
      load_we      = 1'b0;
      accept_point = 1'b0;
      issue        = 1'b0;
      div_start    = 1'b0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            load_we      = start && (req_mode == MODE_LOAD);
            accept_point = start && (req_mode == MODE_POINT);
         end
         ST_MAC: begin
            issue = 1'b1;
         end
         ST_DRAIN: begin
            div_start = drained && !w_zero;
         end
         ST_DIV_X: begin
            div_start = div_done;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign drained = !s1_valid_ff && !s2_valid_ff;
   assign w_zero  = (res_ff[ROW_RES_N-1] == '0);

   //--------------------------------------------------------------------------
   // Configuration port. The register is selected by address bit 2, so each
   // register answers across its whole 32-bit word.
   //--------------------------------------------------------------------------
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_we && csr_paddr[2] == CSR_IDX_WIDTH)  width_in  = csr_pwdata[SCREEN_W-1:0];
      if (cfg_we && csr_paddr[2] == CSR_IDX_HEIGHT) height_in = csr_pwdata[SCREEN_W-1:0];
      csr_prdata = (csr_paddr[2] == CSR_IDX_HEIGHT) ?
                   {{(DATA_W-SCREEN_W){1'b0}}, height_ff} :
                   {{(DATA_W-SCREEN_W){1'b0}}, width_ff};
   end

   //--------------------------------------------------------------------------
   // Matrix store. The step tag is {stage, row, term}, so the address of the
   // entry for row r and term k is stage*16 + 4*k + r, the column-major place.
   //--------------------------------------------------------------------------
   assign mem_addr = {cnt_ff[4], cnt_ff[1:0], cnt_ff[3:2]};

   always_ff @(posedge clock) begin
      if (load_we) begin
         matrix_store_ff[req_entry_index] <= req_entry_value;
      end
      mem_rdata_ff <= matrix_store_ff[mem_addr];
   end

   //--------------------------------------------------------------------------
   // Datapath. Stage 1 multiplies the entry read in the step before by the
   // vector element of its term; stage 2 floors the product by FRAC_BITS and
   // accumulates, saturating on the fourth term of a row. The view stage uses
   // ONE as its fourth element, which adds the translation entry unchanged.
   // The projection rows read the view results, all of which are written
   // before the first projection term that needs the last of them.
   //--------------------------------------------------------------------------
   always_comb begin
      point_in[0] = accept_point ? req_point_x : point_ff[0];
      point_in[1] = accept_point ? req_point_y : point_ff[1];
      point_in[2] = accept_point ? req_point_z : point_ff[2];

      cnt_in      = issue ? cnt_ff + 1'b1 : '0;
      s1_valid_in = issue;
      s1_tag_in   = cnt_ff;
      s2_valid_in = s1_valid_ff;
      s2_tag_in   = s1_tag_ff;

      // Operand selection for the shared multiplier.
      mul_a = {mem_rdata_ff[DATA_W-1], mem_rdata_ff};
      if (s1_tag_ff[4]) begin
         mul_b = res_ff[{1'b0, s1_tag_ff[1:0]}];
      end else begin
         case (s1_tag_ff[1:0])
            2'd0:    mul_b = point_ff[0];
            2'd1:    mul_b = point_ff[1];
            2'd2:    mul_b = point_ff[2];
            default: mul_b = ONE_32;
         endcase
      end
      if (state_ff == ST_VPORT_X) begin
         mul_a = {nx_ff[DATA_W-1], nx_ff} + ONE_33;
         mul_b = $signed({{(DATA_W-SCREEN_W){1'b0}}, width_ff});
      end else if (state_ff == ST_VPORT_Y) begin
         mul_a = ONE_33 - {ny_ff[DATA_W-1], ny_ff};
         mul_b = $signed({{(DATA_W-SCREEN_W){1'b0}}, height_ff});
      end
      product_in = PROD_W'(mul_a) * PROD_W'(mul_b);

      term    = $signed(product_ff[ACC_W-1:0]) >>> FRAC_BITS;
      sum     = ((s2_tag_ff[1:0] == 2'd0) ? ACC_W'(0) : acc_ff) + term;
      acc_in  = s2_valid_ff ? sum : acc_ff;
      res_we  = s2_valid_ff && (s2_tag_ff[1:0] == 2'd3);
      res_idx = {s2_tag_ff[4], s2_tag_ff[3:2]};
      res_in  = sat_w32(sum);

      // Divides: clip x over w, then clip y over w.
      div_num   = (state_ff == ST_DIV_X) ?
                  {res_ff[CLIP_Y_IDX], {FRAC_BITS{1'b0}}} :
                  {res_ff[CLIP_X_IDX], {FRAC_BITS{1'b0}}};
      div_q_ext = ACC_W'(div_quotient);
      div_q_sat = sat_w32(div_q_ext);

      nx_in = nx_ff;
      ny_in = ny_ff;
      wz_in = wz_ff;
      if (state_ff == ST_DRAIN && drained) begin
         wz_in = w_zero;
         nx_in = res_ff[CLIP_X_IDX];
         ny_in = res_ff[CLIP_Y_IDX];
      end
      if (state_ff == ST_DIV_X && div_done) nx_in = div_q_sat;
      if (state_ff == ST_DIV_Y && div_done) ny_in = div_q_sat;

      sx_in = (state_ff == ST_VPORT_Y) ? vport_map(product_ff) : sx_ff;
      sy_in = (state_ff == ST_FINISH)  ? vport_map(product_ff) : sy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         width_ff    <= SCREEN_WIDTH_RESET;
         height_ff   <= SCREEN_HEIGHT_RESET;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      point_ff[0] <= point_in[0];
      point_ff[1] <= point_in[1];
      point_ff[2] <= point_in[2];
      s1_tag_ff   <= s1_tag_in;
      s2_tag_ff   <= s2_tag_in;
      product_ff  <= product_in;
      acc_ff      <= acc_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      wz_ff       <= wz_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      if (res_we) begin
         res_ff[res_idx] <= res_in;
      end
   end

   vts_divider #(
      .NUM_W (NUM_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (res_ff[ROW_RES_N-1]),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   assign rsp_screen_x   = sx_ff;
   assign rsp_screen_y   = sy_ff;
   assign rsp_w_was_zero = wz_ff;

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_result_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobed while the block reports idle");

   a_div_after_drain : assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("divide started before the multiply pipeline emptied");

   a_pipe_in_mac : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("accumulate step outside the multiply phase");

endmodule

`default_nettype wire

>>> src/vts_divider.sv
// Bit-serial signed divider with the quotient truncated toward zero.
// Depends on vts_pkg for the denominator width.
`default_nettype none

module vts_divider
   import vts_pkg::*;
#(
   parameter int NUM_W = DATA_W + FRAC_BITS_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire  signed [NUM_W-1:0]   numerator,
   input  wire  signed [DATA_W-1:0]  denominator,
   output logic                      done,
   output logic signed [NUM_W:0]     quotient
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;

   logic [NUM_W-1:0]  num_mag;
   logic [DATA_W-1:0] den_mag;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              fits;

   always_comb begin
      num_mag = numerator[NUM_W-1] ?
                (~numerator + {{(NUM_W-1){1'b0}}, 1'b1}) : numerator;
      den_mag = denominator[DATA_W-1] ?
                (~denominator + {{(DATA_W-1){1'b0}}, 1'b1}) : denominator;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});

      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;

      if (start) begin
         active_in = 1'b1;
         count_in  = '0;
         quo_in    = num_mag;
         rem_in    = '0;
         den_in    = den_mag;
         neg_in    = numerator[NUM_W-1] ^ denominator[DATA_W-1];
      end else if (active_ff) begin
         // Restoring step: one quotient bit per cycle, MSB first.
         rem_in   = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_LAST) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff)
      else $error("divider started while a divide is running");

   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (active_ff && count_ff != '0) |-> (rem_ff < den_ff))
      else $error("partial remainder not below the divisor");

endmodule

`default_nettype wire

>>> sim/vts_result_checker.sv
// Result checker for the vertex to screen transform testbench: keeps its own copy
// of both matrices and of the viewport registers, predicts every point request,
// checks predictions against result strobes and register reads. Depends on vts_pkg.
module vts_result_checker
   import vts_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,

   input  wire                      start,
   input  wire                      busy,
   input  wire                      req_mode,
   input  wire  [ENTRY_IDX_W-1:0]   req_entry_index,
   input  wire  signed [DATA_W-1:0] req_entry_value,
   input  wire  signed [DATA_W-1:0] req_point_x,
   input  wire  signed [DATA_W-1:0] req_point_y,
   input  wire  signed [DATA_W-1:0] req_point_z,

   input  wire                      rsp_valid,
   input  wire  signed [OUT_W-1:0]  rsp_screen_x,
   input  wire  signed [OUT_W-1:0]  rsp_screen_y,
   input  wire                      rsp_w_was_zero,

   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [DATA_W-1:0]        csr_pwdata,
   input  wire  [DATA_W-1:0]        csr_prdata,
   input  wire                      csr_pready,

   output int                       mismatches,
   output int                       outstanding
);

   localparam longint UNIT    = longint'(1) << FRAC_BITS;
   localparam longint I32_MIN = -(longint'(1) << 31);
   localparam longint I32_MAX = (longint'(1) << 31) - 1;

   typedef struct {
      logic signed [OUT_W-1:0] screen_x;
      logic signed [OUT_W-1:0] screen_y;
      logic                    w_was_zero;
   } screen_point_type;

   // Entries 0-15 hold the view matrix, 16-31 the projection, row + 4 * column.
   int               matrix_copy [32];
   int               vp_width;
   int               vp_height;
   screen_point_type screen_q [$];

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Exact product, then an arithmetic shift, which rounds toward minus infinity.
   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic screen_point_type project_vertex(int px, int py, int pz);
      longint           view_pos [4];
      longint           clip_pos [4];
      longint           nx;
      longint           ny;
      longint           sx;
      longint           sy;
      screen_point_type pix;
      for (int r = 0; r < 4; r++) begin
         view_pos[r] = clamp(fx_mul(matrix_copy[r], px) + fx_mul(matrix_copy[r + 4], py) +
                             fx_mul(matrix_copy[r + 8], pz) + matrix_copy[r + 12],
                             I32_MIN, I32_MAX);
      end
      for (int r = 0; r < 4; r++) begin
         clip_pos[r] = clamp(fx_mul(matrix_copy[16 + r], view_pos[0]) +
                             fx_mul(matrix_copy[20 + r], view_pos[1]) +
                             fx_mul(matrix_copy[24 + r], view_pos[2]) +
                             fx_mul(matrix_copy[28 + r], view_pos[3]), I32_MIN, I32_MAX);
      end
      pix.w_was_zero = (clip_pos[3] == 0);
      if (pix.w_was_zero) begin
         nx = clip_pos[0];
         ny = clip_pos[1];
      end else begin
         nx = clamp((clip_pos[0] * UNIT) / clip_pos[3], I32_MIN, I32_MAX);
         ny = clamp((clip_pos[1] * UNIT) / clip_pos[3], I32_MIN, I32_MAX);
      end
      sx = ((nx + UNIT) * longint'(vp_width)) / (2 * UNIT);
      sy = ((UNIT - ny) * longint'(vp_height)) / (2 * UNIT);
      pix.screen_x = OUT_W'(clamp(sx, -32768, 32767));
      pix.screen_y = OUT_W'(clamp(sy, -32768, 32767));
      return pix;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      screen_point_type want;
      int               want_reg;
      if (reset) begin
         vp_width  = SCREEN_WIDTH_RESET;
         vp_height = SCREEN_HEIGHT_RESET;
         screen_q.delete();
      end else begin
         // A result leaving at this edge belongs to a request accepted earlier,
         // so it is matched before any request accepted at the same edge.
         if (rsp_valid) begin
            if (screen_q.size() == 0) begin
               report_mismatch($sformatf("result (%0d, %0d) with no point request waiting",
                                         rsp_screen_x, rsp_screen_y));
            end else begin
               want = screen_q.pop_front();
               if (rsp_screen_x !== want.screen_x)
                  report_mismatch($sformatf("screen_x is %0d, predicted %0d",
                                            rsp_screen_x, want.screen_x));
               if (rsp_screen_y !== want.screen_y)
                  report_mismatch($sformatf("screen_y is %0d, predicted %0d",
                                            rsp_screen_y, want.screen_y));
               if (rsp_w_was_zero !== want.w_was_zero)
                  report_mismatch($sformatf("w_was_zero is %b, predicted %b",
                                            rsp_w_was_zero, want.w_was_zero));
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_IDX_WIDTH) vp_width = csr_pwdata[SCREEN_W-1:0];
               else vp_height = csr_pwdata[SCREEN_W-1:0];
            end else begin
               want_reg = (csr_paddr[2] == CSR_IDX_WIDTH) ? vp_width : vp_height;
               if (csr_prdata !== DATA_W'(want_reg))
                  report_mismatch($sformatf("register read at %0d gave %0d, expected %0d",
                                            csr_paddr, csr_prdata, want_reg));
            end
         end
         if (start && !busy) begin
            if (req_mode == MODE_LOAD) matrix_copy[req_entry_index] = req_entry_value;
            else screen_q.push_back(project_vertex(req_point_x, req_point_y, req_point_z));
         end
      end
      outstanding <= screen_q.size();
   end

endmodule

>>> sim/tb_vertex_to_screen_transform.sv
// Testbench top for the vertex to screen transform: clock, reset, request and
// register stimulus, watchdog and verdict. Depends on vts_pkg, the block itself
// and vts_result_checker, which does all the prediction and comparison.
module tb_vertex_to_screen_transform;
   import vts_pkg::*;

   localparam int UNIT_ONE        = 1 << FRAC_BITS_DEFAULT;
   localparam int I32_MAX         = 2147483647;
   localparam int I32_MIN         = -2147483647 - 1;
   localparam int PROJ_BASE       = 16;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 300;
   // A point's busy period and the longest sender gap are both shorter than this
   // limit, so a quiet stretch that long can only mean a hang.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int FINAL_WAIT      = 200;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     start           = 1'b0;
   logic                     req_mode        = MODE_LOAD;
   logic [ENTRY_IDX_W-1:0]   req_entry_index = '0;
   logic signed [DATA_W-1:0] req_entry_value = '0;
   logic signed [DATA_W-1:0] req_point_x     = '0;
   logic signed [DATA_W-1:0] req_point_y     = '0;
   logic signed [DATA_W-1:0] req_point_z     = '0;
   logic                     csr_psel        = 1'b0;
   logic                     csr_penable     = 1'b0;
   logic                     csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr       = '0;
   logic [DATA_W-1:0]        csr_pwdata      = '0;

   logic                     busy;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_screen_x;
   logic signed [OUT_W-1:0]  rsp_screen_y;
   logic                     rsp_w_was_zero;
   logic [DATA_W-1:0]        csr_prdata;
   logic                     csr_pready;

   int mismatches;
   int outstanding;
   int sender_idle_pct = 0;
   int items_sent      = 0;
   int quiet_cycles    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vertex_to_screen_transform dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_w_was_zero (rsp_w_was_zero),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   vts_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_w_was_zero (rsp_w_was_zero),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   // The watchdog restarts whenever a request, a result or a register access
   // goes through. A quiet stretch that reaches WATCHDOG_LIMIT is a hang.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Drops start and lets the given number of cycles pass.
   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Presents one request and returns at the edge that accepts it. start is left
   // high, so a request that follows at once goes out back to back; every other
   // path lowers start before the next edge. Most gaps are short, but one in ten
   // is long enough to land anywhere in the busy period of a point.
   task automatic send_request(logic mode, logic [ENTRY_IDX_W-1:0] idx, int value,
                               int px, int py, int pz);
      if ($urandom_range(99) < sender_idle_pct)
         hold_off(($urandom_range(9) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 4));
      req_mode        <= mode;
      req_entry_index <= idx;
      req_entry_value <= value;
      req_point_x     <= px;
      req_point_y     <= py;
      req_point_z     <= pz;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // The unused fields of each kind of request carry random noise.
   task automatic load_entry(int idx, int value);
      send_request(MODE_LOAD, idx[ENTRY_IDX_W-1:0], value, $urandom, $urandom, $urandom);
   endtask

   task automatic send_point(int px, int py, int pz);
      send_request(MODE_POINT, ENTRY_IDX_W'($urandom), $urandom, px, py, pz);
   endtask

   // Waits until every predicted result has come back and the block is idle.
   // Loads finish in the cycle they are accepted, so a short settle is enough
   // before the registers may be touched.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: a setup phase, then the access phase until pready.
   task automatic csr_access(logic is_write, logic idx, int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes both viewport registers, sometimes with junk above the 13 register
   // bits, and reads them back so the checker can compare the read data.
   task automatic set_viewport(int w, int h);
      int junk;
      junk = ($urandom_range(1) == 0) ? 0 : ($urandom & ~32'h1FFF);
      csr_access(1'b1, CSR_IDX_WIDTH, junk | w);
      csr_access(1'b1, CSR_IDX_HEIGHT, junk | h);
      csr_access(1'b0, CSR_IDX_WIDTH, $urandom);
      csr_access(1'b0, CSR_IDX_HEIGHT, $urandom);
   endtask

   function automatic int signed_range(int mag);
      return int'($urandom_range(0, 2 * mag)) - mag;
   endfunction

   // Mostly coordinates within +-32.0, with full-range and extreme values mixed in.
   function automatic int random_coord();
      int k;
      int v;
      k = $urandom_range(99);
      if (k < 80) v = signed_range(32 * UNIT_ONE);
      else if (k < 92) v = $urandom;
      else begin
         case ($urandom_range(4))
            0: v = I32_MIN;
            1: v = I32_MAX;
            2: v = 0;
            3: v = UNIT_ONE;
            default: v = -UNIT_ONE;
         endcase
      end
      return v;
   endfunction

   // Values for single-entry overwrites: small, full range, zero or extreme.
   function automatic int random_entry();
      int k;
      int v;
      k = $urandom_range(99);
      if (k < 50) v = signed_range(4 * UNIT_ONE);
      else if (k < 75) v = $urandom;
      else if (k < 90) v = 0;
      else v = ($urandom_range(1) == 0) ? I32_MIN : I32_MAX;
      return v;
   endfunction

   // Loads a full, plausible camera: an affine view matrix with small rotation
   // terms and a translation, and a perspective-like projection. In a quarter of
   // the scenes the bottom row of the projection is all zero, so clip w is zero
   // for every point; in another quarter w also gets a constant term.
   task automatic load_scene();
      int w_kind;
      int v;
      w_kind = $urandom_range(3);
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (r == 3) v = (c == 3) ? UNIT_ONE : 0;
            else if (c == 3) v = signed_range(8 * UNIT_ONE);
            else if ($urandom_range(4) == 0) v = 0;
            else v = signed_range(UNIT_ONE);
            load_entry(r + 4 * c, v);
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v = 0;
            if (r == 3) begin
               if (w_kind != 0 && c == 2) v = -UNIT_ONE;
               else if (w_kind == 3 && c == 3) v = signed_range(UNIT_ONE);
            end else if (r == c || (r == 2 && c == 3)) begin
               v = signed_range(3 * UNIT_ONE);
            end else if ($urandom_range(9) == 0) begin
               v = signed_range(UNIT_ONE);
            end
            load_entry(PROJ_BASE + r + 4 * c, v);
         end
      end
   endtask

   initial begin
      int phase_width  [NUM_PHASES] = '{1, 4096, 8191, 0, 0, 640};
      int phase_height [NUM_PHASES] = '{1, 4096, 0, 8191, 0, 480};
      int phase_idle   [NUM_PHASES] = '{0, 69, 0, 18, 69, 18};
      int phase_start;
      int pick;
      int w;
      int h;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset values of both registers are checked on the first reads.
      csr_access(1'b0, CSR_IDX_WIDTH, $urandom);
      csr_access(1'b0, CSR_IDX_HEIGHT, $urandom);

      // Directed part. Every entry is loaded before the first point, since the
      // store holds garbage until written. Both matrices start as identity, so
      // a point maps straight onto the 640 by 480 reset viewport.
      for (int i = 0; i < 32; i++)
         load_entry(i, ((i % 4) == ((i % 16) / 4)) ? UNIT_ONE : 0);
      send_point(0, 0, 0);
      send_point(UNIT_ONE, UNIT_ONE, 0);
      send_point(-UNIT_ONE, -UNIT_ONE, 0);
      send_point(I32_MAX, I32_MAX, I32_MAX);
      send_point(I32_MIN, I32_MIN, I32_MIN);
      send_point(UNIT_ONE / 3, -UNIT_ONE / 7, 5 * UNIT_ONE);
      // With the bottom right projection entry cleared, clip w is zero and the
      // divide is skipped; the screen fields still come from clip x and y.
      load_entry(PROJ_BASE + 15, 0);
      send_point(UNIT_ONE / 4, -UNIT_ONE / 4, 0);
      send_point(I32_MAX, I32_MIN, 0);
      // Now w = -z: a positive w, a negative w, and a w of one raw step, which
      // drives the quotient into saturation.
      load_entry(PROJ_BASE + 11, -UNIT_ONE);
      send_point(UNIT_ONE, UNIT_ONE, -2 * UNIT_ONE);
      send_point(3 * UNIT_ONE, -UNIT_ONE, UNIT_ONE);
      send_point(UNIT_ONE, -UNIT_ONE, 1);
      // Extreme matrix entries: one saturates the view stage, one drives it to its limit.
      load_entry(0, I32_MIN);
      send_point(I32_MAX, 0, -UNIT_ONE);
      load_entry(0, I32_MAX);
      send_point(-UNIT_ONE, UNIT_ONE, -UNIT_ONE);
      load_entry(0, UNIT_ONE);
      drain_results();

      // Random part. Each phase runs at its own viewport setting, including
      // the register extremes and zero, and with its own sender idle rate.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         w = phase_width[phase];
         h = phase_height[phase];
         if (w == 0 && h == 0) begin
            w = $urandom_range(1, 4096);
            h = $urandom_range(1, 4096);
         end
         set_viewport(w, h);
         sender_idle_pct = phase_idle[phase];
         phase_start = items_sent;
         load_scene();
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            // Now and then switch idling off for a stretch, or back on.
            if ($urandom_range(49) == 0)
               sender_idle_pct = (sender_idle_pct == 0) ? phase_idle[phase] : 0;
            if (pick < 3) begin
               load_scene();
            end else if (pick < 10) begin
               repeat ($urandom_range(1, 4)) load_entry($urandom_range(31), random_entry());
            end else if (pick < 12) begin
               // Hold the next request until every result so far is back.
               drain_results();
            end else begin
               send_point(random_coord(), random_coord(), random_coord());
            end
         end
         drain_results();
      end

      repeat (FINAL_WAIT) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
